// ===== src/wbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared widths, register indexes, reset values and the structs that pass
// between the scanner's top level and its pattern matcher.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Field widths fixed by the stream and register interface.
  localparam int BYTE_W      = 8;
  localparam int LEN_REG_W   = 7;
  localparam int PIDX_W      = 6;
  localparam int RESULT_W    = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH  = 2'd0,
    REG_WILDCARD_ENABLE = 2'd1,
    REG_WILDCARD_VALUE  = 2'd2
  } reg_idx_e;

  // Input item kinds carried on tuser.
  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_DATA    = 1'b1
  } item_kind_e;

  // Register reset values; the wildcard defaults to the '?' character.
  localparam logic [LEN_REG_W-1:0] LEN_RST    = 7'd1;
  localparam logic                 WC_EN_RST  = 1'b1;
  localparam logic [BYTE_W-1:0]    WC_VAL_RST = 8'd63;

  // Wildcard settings seen by the matcher.
  typedef struct packed {
    logic              wc_en;
    logic [BYTE_W-1:0] wc_val;
  } wc_cfg_t;

  // One pattern store write request.
  typedef struct packed {
    logic              we;
    logic [PIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } pat_wr_t;

endpackage
`default_nettype wire

// ===== src/wbps_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte window shift register
// Holds the most recent region bytes, newest in the lowest byte lane, and
// clears them when a region ends.
// ----------------------------------------------------------------------------
module wbps_window #(
  parameter int PATTERN_MAX = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     shift_i,
  input  wire logic                     clear_i,
  input  wire logic [7:0]               byte_i,
  output logic      [PATTERN_MAX*8-1:0] win_next_o
);
  import wbps_pkg::*;

  logic [PATTERN_MAX*BYTE_W-1:0] win_q;
  logic [PATTERN_MAX*BYTE_W-1:0] win_d;

  // The window after the incoming byte has been shifted in.
  generate
    if (PATTERN_MAX > 1) begin : g_shift
      assign win_next_o = {win_q[(PATTERN_MAX-1)*BYTE_W-1:0], byte_i};
    end else begin : g_single
      assign win_next_o = byte_i;
    end
  endgenerate

  // A region end empties the window after its last byte has been checked.
  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      win_d = clear_i ? '0 : win_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/wbps_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern store and parallel matcher
// Stores the pattern bytes and compares every pattern position against the
// window combinationally, after aligning the window to the active length.
// ----------------------------------------------------------------------------
module wbps_matcher #(
  parameter int PATTERN_MAX = 64,
  parameter int LenW        = 7,
  parameter int IdxW        = 6
) (
  input  wire logic                     clk_i,
  input  wire wbps_pkg::pat_wr_t        pat_wr_i,
  input  wire wbps_pkg::wc_cfg_t        wc_i,
  input  wire logic [LenW-1:0]          len_i,
  input  wire logic [PATTERN_MAX*8-1:0] window_i,
  output logic                          hit_o
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0]             pat_q [PATTERN_MAX];
  logic [PATTERN_MAX*BYTE_W-1:0] rev_win;
  logic [PATTERN_MAX*BYTE_W-1:0] aligned;
  logic [LenW-1:0]               shamt_wide;
  logic [IdxW-1:0]               shamt;
  logic [PATTERN_MAX-1:0]        pos_ok;

  // Pattern bytes are written by address; indexes past the store are dropped.
  for (genvar e = 0; e < PATTERN_MAX; e++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (pat_wr_i.we && (int'(pat_wr_i.idx) == e)) begin
        pat_q[e] <= pat_wr_i.data;
      end
    end
  end

  // Reverse the window so the oldest byte sits in the lowest lane.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_rev
    assign rev_win[i*BYTE_W +: BYTE_W] = window_i[(PATTERN_MAX-1-i)*BYTE_W +: BYTE_W];
  end

  // Shifting out the unused oldest lanes lines up pattern byte k with lane k.
  assign shamt_wide = LenW'(PATTERN_MAX) - len_i;
  assign shamt      = shamt_wide[IdxW-1:0];
  assign aligned    = rev_win >> {shamt, 3'b000};

  // Each position matches exactly, by wildcard, or lies beyond the length.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
    logic in_use;
    logic wild;
    logic same;
    assign in_use    = LenW'(k) < len_i;
    assign wild      = wc_i.wc_en && (pat_q[k] == wc_i.wc_val);
    assign same      = pat_q[k] == aligned[k*BYTE_W +: BYTE_W];
    assign pos_ok[k] = wild || same || !in_use;
  end

  assign hit_o = &pos_ok;

endmodule
`default_nettype wire

// ===== src/wildcard_byte_pattern_scanner_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Searches a byte stream for non-overlapping matches of a loaded pattern in
// which a chosen byte value may act as a wildcard.
// ----------------------------------------------------------------------------
// Usage:
//   Load the pattern over the slave stream with tuser low: tdata[7:0] is the
//   byte and tdata[13:8] its position. Set the length and wildcard settings
//   through the register write port while no request is in flight. Then
//   stream region bytes with tuser high and tlast on the final byte.
//   The master stream carries one result for every byte that ends a match
//   or closes a region; other bytes and pattern loads give no result.
// Timing:
//   A request is captured in the input register and is evaluated from there
//   into the result register, which presents its result. One request is
//   taken per cycle while the result consumer keeps up: the whole pattern
//   is compared with the byte window combinationally.
// Reset and stalls:
//   Reset clears the window, position, counters and the valid flags of both
//   pipeline registers and loads the default registers (length 1, wildcard
//   '?' enabled). The pattern store is not reset and must be loaded before
//   use. When the result consumer stalls, the pipeline holds and tready
//   drops once the input register is full.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit #(
  parameter int PATTERN_MAX = 64,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Register write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // byte_value[7:0], pattern_index[13:8], zero pad
  input  wire logic        s_axis_tuser,  // kind
  input  wire logic        s_axis_tlast,  // last_of_region
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // match_found[0], match_offset[32:1],
                                          // match_total[64:33], zero pad
  output logic             m_axis_tlast   // region_end
);
  import wbps_pkg::*;

  localparam int LenW = $clog2(PATTERN_MAX + 1);
  localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CmpW = (LenW > LEN_REG_W) ? LenW : LEN_REG_W;

  // Configuration registers.
  logic [LEN_REG_W-1:0] len_reg_q;
  logic                 wc_en_q;
  logic [BYTE_W-1:0]    wc_val_q;

  // Input register.
  logic              in_valid_q;
  logic              in_kind_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic [PIDX_W-1:0] in_idx_q;
  logic              in_last_q;

  // Per-region state.
  logic [OFFSET_BITS-1:0] pos_q;
  logic [LenW-1:0]        bsm_q;
  logic [RESULT_W-1:0]    cnt_q;

  // Result register.
  logic                out_valid_q;
  logic                out_found_q;
  logic [RESULT_W-1:0] out_offset_q;
  logic                out_end_q;
  logic [RESULT_W-1:0] out_total_q;

  logic                         out_free;
  logic                         proc_en;
  logic                         data_en;
  logic                         emit;
  logic [LenW-1:0]              act_len;
  logic [LenW-1:0]              bsm_inc;
  logic                         hit;
  logic                         found;
  logic [OFFSET_BITS-1:0]       start_full;
  logic [OFFSET_BITS+RESULT_W-1:0] start_ext;
  logic [RESULT_W-1:0]          cnt_next;
  logic [PATTERN_MAX*BYTE_W-1:0] win_next;
  pat_wr_t                      pat_wr;
  wc_cfg_t                      wc_cfg;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q <= LEN_RST;
      wc_en_q   <= WC_EN_RST;
      wc_val_q  <= WC_VAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_LENGTH:  len_reg_q <= cfg_wdata_i[LEN_REG_W-1:0];
        REG_WILDCARD_ENABLE: wc_en_q   <= cfg_wdata_i[0];
        REG_WILDCARD_VALUE:  wc_val_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: the input register advances whenever the result slot
  // is empty or is being taken.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc_en       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[BYTE_W-1:0];
      in_idx_q  <= s_axis_tdata[BYTE_W +: PIDX_W];
      in_last_q <= s_axis_tlast;
    end
  end

  assign data_en = proc_en && (in_kind_q == KIND_DATA);

  // Active pattern length: zero counts as one, large values saturate.
  always_comb begin
    act_len = LenW'(1);
    if (len_reg_q == '0) begin
      act_len = LenW'(1);
    end else if (CmpW'(len_reg_q) > CmpW'(PATTERN_MAX)) begin
      act_len = LenW'(PATTERN_MAX);
    end else begin
      act_len = LenW'(CmpW'(len_reg_q));
    end
  end

  assign pat_wr.we   = proc_en && (in_kind_q == KIND_PATTERN);
  assign pat_wr.idx  = in_idx_q;
  assign pat_wr.data = in_byte_q;

  assign wc_cfg.wc_en  = wc_en_q;
  assign wc_cfg.wc_val = wc_val_q;

  wbps_window #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (data_en),
    .clear_i    (in_last_q),
    .byte_i     (in_byte_q),
    .win_next_o (win_next)
  );

  wbps_matcher #(
    .PATTERN_MAX(PATTERN_MAX),
    .LenW       (LenW),
    .IdxW       (IdxW)
  ) u_matcher (
    .clk_i    (clk_i),
    .pat_wr_i (pat_wr),
    .wc_i     (wc_cfg),
    .len_i    (act_len),
    .window_i (win_next),
    .hit_o    (hit)
  );

  // A match counts only once enough bytes followed the region start or the
  // previous match.
  assign bsm_inc    = (bsm_q < LenW'(PATTERN_MAX)) ? bsm_q + LenW'(1) : bsm_q;
  assign found      = hit && (bsm_inc >= act_len);
  assign start_full = pos_q - OFFSET_BITS'(act_len) + OFFSET_BITS'(1);
  assign start_ext  = {{RESULT_W{1'b0}}, start_full};
  assign cnt_next   = (found && (cnt_q != '1)) ? cnt_q + RESULT_W'(1) : cnt_q;
  assign emit       = data_en && (found || in_last_q);

  // Region state: advance on each data byte, clear after the region's end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      bsm_q <= '0;
      cnt_q <= '0;
    end else if (data_en) begin
      if (in_last_q) begin
        pos_q <= '0;
        bsm_q <= '0;
        cnt_q <= '0;
      end else begin
        pos_q <= pos_q + OFFSET_BITS'(1);
        bsm_q <= found ? '0 : bsm_inc;
        cnt_q <= cnt_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      out_found_q  <= found;
      out_offset_q <= found ? start_ext[RESULT_W-1:0] : '0;
      out_end_q    <= in_last_q;
      out_total_q  <= in_last_q ? cnt_next : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_total_q, out_offset_q, out_found_q};
  assign m_axis_tlast  = out_end_q;

  // A result that does not close a region must report a match.
  a_result_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tdata[0])
    else $error("result without a match or region end");

  // Without a match the start offset reads as zero.
  a_offset_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
    else $error("offset set on a result without a match");

  // The match total is only reported with the region end.
  a_total_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[64:33] == '0))
    else $error("match total set before the region end");

  // The byte count since the last match never passes the store depth.
  a_bsm_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bsm_q <= LenW'(PATTERN_MAX))
    else $error("byte count since match out of range");

  // A region end returns the position counter to zero.
  a_region_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_en && in_last_q) |=> (pos_q == '0))
    else $error("region position not cleared at region end");

endmodule
`default_nettype wire

// ===== tb/tb_wildcard_byte_pattern_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner testbench
// Loads patterns and streams region bytes under several register settings
// and idle patterns. A scoreboard keeps its own copy of the pattern, window
// and region counters, works out each match and region summary, and compares
// every result field in order.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scanner_unit;
  import wbps_pkg::*;

  localparam int PAT_MAX      = 64;
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_REQS   = 150;
  localparam int NUM_PHASES   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One request on the input stream.
  typedef struct packed {
    item_kind_e        kind;
    logic [BYTE_W-1:0] value;
    logic [PIDX_W-1:0] index;
    logic              last;
  } scan_req_t;

  // One result on the output stream.
  typedef struct packed {
    logic                found;
    logic [RESULT_W-1:0] offset;
    logic                region_end;
    logic [RESULT_W-1:0] total;
  } scan_hit_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  wildcard_byte_pattern_scanner_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  scan_req_t pending_reqs[$];
  scan_hit_t expected_hits[$];
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int sent_reqs     = 0;
  int taken_reqs    = 0;
  int queued_reqs   = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;

  // Scoreboard copy of the block state, updated on accepted requests.
  logic [BYTE_W-1:0]    mdl_pattern[PAT_MAX];
  logic [BYTE_W-1:0]    mdl_window[PAT_MAX];
  logic [RESULT_W-1:0]  mdl_pos     = '0;
  logic [RESULT_W-1:0]  mdl_count   = '0;
  int                   mdl_since   = 0;
  logic [LEN_REG_W-1:0] mdl_len_reg = LEN_RST;
  logic                 mdl_wc_en   = WC_EN_RST;
  logic [BYTE_W-1:0]    mdl_wc_val  = WC_VAL_RST;

  // Stimulus-side view of the pattern and settings, used to build matches.
  logic [BYTE_W-1:0] gen_pattern[PAT_MAX];
  int                gen_len = 1;
  logic              gen_wce = WC_EN_RST;
  logic [BYTE_W-1:0] gen_wcv = WC_VAL_RST;

  // Length zero acts as one; anything past the store size saturates.
  function automatic int active_len(logic [LEN_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > PAT_MAX) return PAT_MAX;
    return int'(r);
  endfunction

  // The oldest window byte lines up with pattern entry zero.
  function automatic bit window_hit(int len);
    int k;
    logic [BYTE_W-1:0] p;
    for (k = 0; k < len; k++) begin
      p = mdl_pattern[k];
      if (!(mdl_wc_en && p == mdl_wc_val) && p != mdl_window[len - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Shift in one region byte and queue the result it causes, if any.
  task automatic predict_byte(logic [BYTE_W-1:0] b, logic last);
    int len;
    int i;
    bit found;
    logic [RESULT_W-1:0] start;
    scan_hit_t hit;
    len = active_len(mdl_len_reg);
    for (i = PAT_MAX - 1; i > 0; i--) mdl_window[i] = mdl_window[i - 1];
    mdl_window[0] = b;
    if (mdl_since < PAT_MAX) mdl_since++;
    found = 1'b0;
    start = '0;
    if (mdl_since >= len && window_hit(len)) begin
      found = 1'b1;
      start = mdl_pos - RESULT_W'(len) + 32'd1;
      mdl_since = 0;
      if (mdl_count != '1) mdl_count++;
    end
    mdl_pos++;
    if (found || last) begin
      hit.found      = found;
      hit.offset     = found ? start : '0;
      hit.region_end = last;
      hit.total      = last ? mdl_count : '0;
      expected_hits.insert(expected_hits.size(), hit);
    end
    // Region end clears the per-region state after the result is formed.
    if (last) begin
      for (i = 0; i < PAT_MAX; i++) mdl_window[i] = '0;
      mdl_pos   = '0;
      mdl_since = 0;
      mdl_count = '0;
    end
  endtask

  // Scoreboard and watchdog: sample register writes and both streams.
  always @(posedge clk_i) begin : scoreboard
    scan_hit_t want;
    scan_hit_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_LENGTH:  mdl_len_reg = cfg_wdata_i[LEN_REG_W-1:0];
          REG_WILDCARD_ENABLE: mdl_wc_en = cfg_wdata_i[0];
          REG_WILDCARD_VALUE:  mdl_wc_val = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.found      = m_axis_tdata[0];
        got.offset     = m_axis_tdata[32:1];
        got.total      = m_axis_tdata[64:33];
        got.region_end = m_axis_tlast;
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: found=%0b offset=%0d end=%0b total=%0d",
                     got.found, got.offset, got.region_end, got.total);
        end else begin
          want = expected_hits.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result mismatch: expected found=%0b offset=%0d end=%0b ",
                        "total=%0d, got found=%0b offset=%0d end=%0b total=%0d"},
                       want.found, want.offset, want.region_end, want.total,
                       got.found, got.offset, got.region_end, got.total);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken_reqs++;
        if (s_axis_tuser == KIND_PATTERN)
          mdl_pattern[s_axis_tdata[13:8]] = s_axis_tdata[7:0];
        else
          predict_byte(s_axis_tdata[7:0], s_axis_tlast);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Request driver and result-side stalls, both changing on the falling edge.
  always @(negedge clk_i) begin : stream_driver
    scan_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      if (!s_axis_tvalid || taken_reqs == sent_reqs) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req = pending_reqs.pop_front();
          sent_reqs++;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, req.index, req.value};
          s_axis_tuser  <= req.kind;
          s_axis_tlast  <= req.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic push_data(logic [BYTE_W-1:0] b, logic last);
    scan_req_t req;
    req.kind  = KIND_DATA;
    req.value = b;
    req.index = PIDX_W'($urandom_range(PAT_MAX - 1));
    req.last  = last;
    pending_reqs.insert(pending_reqs.size(), req);
    queued_reqs++;
  endtask

  task automatic push_load(int idx, logic [BYTE_W-1:0] b);
    scan_req_t req;
    req.kind  = KIND_PATTERN;
    req.value = b;
    req.index = PIDX_W'(idx);
    req.last  = 1'($urandom_range(1));
    pending_reqs.insert(pending_reqs.size(), req);
    queued_reqs++;
    gen_pattern[idx] = b;
  endtask

  // Registers change only once every request has drained out of the block.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || sent_reqs != taken_reqs ||
           expected_hits.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH:  gen_len = active_len(v[LEN_REG_W-1:0]);
      REG_WILDCARD_ENABLE: gen_wce = v[0];
      REG_WILDCARD_VALUE:  gen_wcv = v;
      default: ;
    endcase
  endtask

  // A copy of pattern byte k, with wildcard positions filled at random.
  function automatic logic [BYTE_W-1:0] instance_byte(int k);
    if (gen_wce && gen_pattern[k] == gen_wcv) return BYTE_W'($urandom_range(255));
    return gen_pattern[k];
  endfunction

  // One region: whole pattern copies mixed with filler bytes, the filler
  // either fully random or drawn from the pattern's own bytes so that
  // partial and overlapping candidates show up. Stray pattern writes are
  // sprinkled in between.
  task automatic gen_region(int units, int embed_pct, bit wide_alpha);
    logic [BYTE_W-1:0] bytes[$];
    logic [BYTE_W-1:0] b;
    int u;
    int k;
    int j;
    for (u = 0; u < units; u++) begin
      if ($urandom_range(99) < embed_pct) begin
        for (k = 0; k < gen_len; k++) bytes.insert(bytes.size(), instance_byte(k));
      end else if (wide_alpha) begin
        bytes.insert(bytes.size(), BYTE_W'($urandom_range(255)));
      end else begin
        b = gen_pattern[$urandom_range(gen_len - 1)];
        if ($urandom_range(3) == 0) b = BYTE_W'($urandom_range(255));
        bytes.insert(bytes.size(), b);
      end
    end
    for (j = 0; j < bytes.size(); j++) begin
      if ($urandom_range(99) < 3)
        push_load($urandom_range(PAT_MAX - 1), BYTE_W'($urandom_range(255)));
      push_data(bytes[j], j == bytes.size() - 1);
    end
  endtask

  initial begin : stimulus
    int i;
    int phase;
    int first;
    int r;
    logic [CFG_DATA_W-1:0] len_v;
    logic [CFG_DATA_W-1:0] wcv_v;
    logic wce_v;
    logic [BYTE_W-1:0] sym[3];
    for (i = 0; i < PAT_MAX; i++) mdl_window[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default settings, length one: each byte equal to entry zero matches,
    // back to back, including a single-byte region.
    push_load(0, 8'hFF);
    push_load(PAT_MAX - 1, 8'h00);
    push_data(8'h00, 1'b0);
    push_data(8'hFF, 1'b0);
    push_data(8'hFF, 1'b0);
    push_data(8'h12, 1'b1);
    push_data(8'hFF, 1'b1);
    wait_idle();

    // Length zero acts as one; the only pattern byte is now the wildcard.
    write_reg(REG_PATTERN_LENGTH, 8'd0);
    write_reg(REG_WILDCARD_VALUE, 8'hFF);
    push_data(8'h55, 1'b0);
    push_data(8'h00, 1'b1);
    wait_idle();

    // Exact search of a repeating pattern: matches must not overlap, and a
    // region shorter than the pattern reports no match.
    write_reg(REG_PATTERN_LENGTH, 8'd3);
    write_reg(REG_WILDCARD_ENABLE, 8'd0);
    write_reg(REG_WILDCARD_VALUE, 8'h3F);
    push_load(0, 8'h3F);
    push_load(1, 8'hAB);
    push_load(2, 8'h3F);
    push_data(8'h3F, 1'b0);
    push_data(8'hAB, 1'b0);
    push_data(8'h3F, 1'b0);
    push_data(8'hAB, 1'b0);
    push_data(8'h3F, 1'b0);
    push_data(8'hAB, 1'b0);
    push_data(8'h3F, 1'b1);
    push_data(8'hAB, 1'b0);
    push_data(8'h3F, 1'b1);
    wait_idle();

    // Same pattern with wildcards on; the match ends on the region's last byte.
    write_reg(REG_WILDCARD_ENABLE, 8'd1);
    push_data(8'h00, 1'b0);
    push_data(8'hAB, 1'b0);
    push_data(8'hFF, 1'b1);

    // Fill every pattern entry so any length reads written entries only.
    for (i = 0; i < PAT_MAX; i++) push_load(i, BYTE_W'($urandom_range(255)));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
        default: begin src_idle_pct = 16; snk_stall_pct = 16; end
      endcase
      case (phase)
        0: begin len_v = 8'd1;   wce_v = 1'b1; wcv_v = 8'h3F; end
        1: begin len_v = 8'd2;   wce_v = 1'b0; wcv_v = 8'h00; end
        2: begin len_v = 8'd4;   wce_v = 1'b1; wcv_v = 8'h00; end
        3: begin len_v = 8'd8;   wce_v = 1'b1; wcv_v = 8'hFF; end
        4: begin len_v = 8'd64;  wce_v = 1'b1; wcv_v = 8'h3F; end
        5: begin len_v = 8'hC3;  wce_v = 1'b0; wcv_v = 8'hA5; end
        6: begin len_v = 8'd0;   wce_v = 1'b1; wcv_v = 8'h80; end
        default: begin len_v = 8'd5; wce_v = 1'b1; wcv_v = BYTE_W'($urandom_range(255)); end
      endcase
      write_reg(REG_PATTERN_LENGTH, len_v);
      write_reg(REG_WILDCARD_ENABLE, {7'd0, wce_v});
      write_reg(REG_WILDCARD_VALUE, wcv_v);
      // A write past the register list must leave the settings alone.
      if (phase == 5) write_reg(REG_UNUSED, BYTE_W'($urandom_range(255)));

      // New pattern over a small alphabet, with wildcards sprinkled in.
      for (i = 0; i < 3; i++) sym[i] = BYTE_W'($urandom_range(255));
      for (i = 0; i < gen_len; i++) begin
        r = $urandom_range(99);
        if (r < 25) push_load(i, gen_wcv);
        else if (r < 70) push_load(i, sym[$urandom_range(2)]);
        else push_load(i, BYTE_W'($urandom_range(255)));
      end

      first = queued_reqs;
      while (queued_reqs - first < PHASE_REQS) begin
        if ($urandom_range(9) == 0)
          gen_region($urandom_range(40, 13), 35, $urandom_range(3) == 0);
        else
          gen_region($urandom_range(8, 1), 35, $urandom_range(3) == 0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
